// ===== rtl/core/rbb_pkg.sv =====
// ---------------------------------------------------------------------------
// rbb_pkg: shared types and constants for the RGB box blur
// Pixel layout, command and register index codes, fixed field widths.
// ---------------------------------------------------------------------------
`default_nettype none

package rbb_pkg;

    localparam int PIX_W        = 8;
    localparam int NUM_CH       = 3;
    localparam int RGB_W        = PIX_W * NUM_CH;

    // input beat command
    localparam logic CMD_PIXEL  = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    // configuration port
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int MAX_HEIGHT   = 4096;

    // input row counter runs past the frame height while draining
    localparam int ROW_W        = 14;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_rgb;

endpackage

`default_nettype wire

// ===== rtl/core/rgb_box_blur_5x5_unit.sv =====
// ---------------------------------------------------------------------------
// rgb_box_blur_5x5_unit: streaming RGB box blur over a KxK window
// Line buffer plus a chain of column cells; per channel floor(sum / K*K).
// ---------------------------------------------------------------------------
// Throughput: one beat per cycle unless stalled, set by the single line buffer
// read and write per beat and the one-column shift of the cell chain.
// Path: a completing beat passes stage 1, the column cells, stage 3 and
// the output register; it comes (K-1-K/2) rows and columns after the centered pixel.
// Reset clears counters and valid bits and loads 640 x 480; the line
// buffer is not cleared, rows are masked until written in each frame.
`default_nettype none

module rgb_box_blur_5x5_unit #(
    parameter int KERNEL_SIZE = 5,
    parameter int MAX_WIDTH   = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [rbb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rbb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_command,
    input  wire logic [rbb_pkg::PIX_W-1:0]      i_pixel_red,
    input  wire logic [rbb_pkg::PIX_W-1:0]      i_pixel_green,
    input  wire logic [rbb_pkg::PIX_W-1:0]      i_pixel_blue,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic      [rbb_pkg::PIX_W-1:0]      o_out_red,
    output logic      [rbb_pkg::PIX_W-1:0]      o_out_green,
    output logic      [rbb_pkg::PIX_W-1:0]      o_out_blue,
    output logic                                o_frame_end
);

    import rbb_pkg::*;

    localparam int HALF    = KERNEL_SIZE / 2;
    localparam int LAG     = KERNEL_SIZE - 1 - HALF;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int FW_W    = $clog2(MAX_WIDTH + 1);
    localparam int OW      = COL_W + 2;
    localparam int TAPS    = KERNEL_SIZE - 1;
    localparam int WORD_W  = TAPS * RGB_W;
    localparam int PIX_MAX = (1 << PIX_W) - 1;
    localparam int CSUM_W  = $clog2(KERNEL_SIZE * PIX_MAX + 1);
    localparam int DIV     = KERNEL_SIZE * KERNEL_SIZE;
    localparam int ACC_W   = $clog2(DIV * PIX_MAX + 1);
    localparam int DIV_L   = $clog2(DIV);
    localparam int SHIFT   = ACC_W + DIV_L;
    localparam int MUL_W   = ACC_W + 2;
    localparam int PROD_W  = ACC_W + MUL_W;
    localparam longint unsigned MUL = ((64'd1 << SHIFT) + DIV - 1) / DIV;
    localparam int LEAD_W  = $clog2(LAG * MAX_WIDTH + LAG + 1);

    typedef struct packed {
        logic             emit;
        logic             last;
        logic [COL_W-1:0] oc;
        logic [FW_W-1:0]  fw;
    } t_meta;

    // configuration registers
    logic [WIDTH_REG_W-1:0]  r_cfg_w;
    logic [HEIGHT_REG_W-1:0] r_cfg_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= WIDTH_REG_W'(WIDTH_RESET);
            r_cfg_h <= HEIGHT_REG_W'(HEIGHT_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data[WIDTH_REG_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp the frame size
    logic [FW_W-1:0]         cfg_w_clamp;
    logic [HEIGHT_REG_W-1:0] cfg_h_clamp;

    always_comb begin
        if (r_cfg_w == '0) begin
            cfg_w_clamp = FW_W'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            cfg_w_clamp = FW_W'(MAX_WIDTH);
        end else begin
            cfg_w_clamp = FW_W'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            cfg_h_clamp = HEIGHT_REG_W'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            cfg_h_clamp = HEIGHT_REG_W'(MAX_HEIGHT);
        end else begin
            cfg_h_clamp = r_cfg_h;
        end
    end

    // position counters
    logic [COL_W-1:0]        r_in_col;
    logic [ROW_W-1:0]        r_in_row;
    logic [COL_W-1:0]        r_out_col;
    logic [HEIGHT_REG_W-1:0] r_out_row;
    logic [LEAD_W-1:0]       r_lead;
    logic [FW_W-1:0]         r_fw;
    logic [HEIGHT_REG_W-1:0] r_fh;

    logic                    adv;
    logic                    start;
    logic [FW_W-1:0]         fw_e;
    logic [HEIGHT_REG_W-1:0] fh_e;
    logic                    in_frame;
    logic                    drop;
    logic                    take;
    logic [LEAD_W-1:0]       delay;
    logic                    emit;
    logic                    last;
    logic [COL_W:0]          in_col_inc;
    logic [COL_W:0]          out_col_inc;
    logic [HEIGHT_REG_W:0]   out_row_inc;
    t_rgb                    pix_in;

    assign adv        = !o_out_valid || !i_out_stall;
    assign o_in_stall = !adv;

    always_comb begin
        start       = (r_in_row == '0) && (r_in_col == '0);
        fw_e        = start ? cfg_w_clamp : r_fw;
        fh_e        = start ? cfg_h_clamp : r_fh;
        in_frame    = r_in_row < ROW_W'(fh_e);
        drop        = (i_command == CMD_DRAIN) && in_frame;
        take        = i_in_valid && adv && !drop;
        delay       = LEAD_W'(LAG) * LEAD_W'(fw_e) + LEAD_W'(LAG);
        emit        = (r_lead == delay);
        in_col_inc  = (COL_W + 1)'(r_in_col) + 1'b1;
        out_col_inc = (COL_W + 1)'(r_out_col) + 1'b1;
        out_row_inc = (HEIGHT_REG_W + 1)'(r_out_row) + 1'b1;
        last        = emit && (out_row_inc >= (HEIGHT_REG_W + 1)'(fh_e))
                           && (out_col_inc >= (COL_W + 1)'(fw_e));
        // discard data of pixels past the frame
        if ((i_command == CMD_PIXEL) && in_frame) begin
            pix_in = '{blue: i_pixel_blue, green: i_pixel_green, red: i_pixel_red};
        end else begin
            pix_in = '0;
        end
    end

    // advance input and output positions on each taken beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_lead    <= '0;
            r_fw      <= '0;
            r_fh      <= '0;
        end else if (take) begin
            if (start) begin
                r_fw <= cfg_w_clamp;
                r_fh <= cfg_h_clamp;
            end
            if (last) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
                r_lead    <= '0;
            end else begin
                if (in_col_inc >= (COL_W + 1)'(fw_e)) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + 1'b1;
                end else begin
                    r_in_col <= in_col_inc[COL_W-1:0];
                end
                if (!emit) begin
                    r_lead <= r_lead + 1'b1;
                end else if (out_col_inc >= (COL_W + 1)'(fw_e)) begin
                    r_out_col <= '0;
                    r_out_row <= out_row_inc[HEIGHT_REG_W-1:0];
                end else begin
                    r_out_col <= out_col_inc[COL_W-1:0];
                end
            end
        end
    end

    // stage 1: line buffer read data arrives with the beat
    logic                    r_s1_v;
    logic [COL_W-1:0]        r_s1_col;
    logic [ROW_W-1:0]        r_s1_row;
    logic [HEIGHT_REG_W-1:0] r_s1_fh;
    t_rgb                    r_s1_pix;
    t_meta                   r_s1_meta;

    logic                    r_s2_v;
    t_meta                   r_s2_meta;

    logic                    r_s3_v;
    t_meta                   r_s3_meta;
    logic [NUM_CH-1:0][ACC_W-1:0] r_s3_sum;

    logic                    r_out_valid;
    t_rgb                    r_out_pix;
    logic                    r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_v      <= take;
            r_s2_v      <= r_s1_v;
            r_s3_v      <= r_s2_v;
            r_out_valid <= r_s3_v && r_s3_meta.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_col  <= r_in_col;
            r_s1_row  <= r_in_row;
            r_s1_fh   <= fh_e;
            r_s1_pix  <= pix_in;
            r_s1_meta <= '{emit: emit, last: last, oc: r_out_col, fw: fw_e};
        end
    end

    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] wr_word;

    rbb_line_buf #(
        .DEPTH  (MAX_WIDTH),
        .WORD_W (WORD_W)
    ) u_lbuf (
        .i_clk   (i_clk),
        .i_re    (adv),
        .i_raddr (r_in_col),
        .i_we    (adv && r_s1_v),
        .i_waddr (r_s1_col),
        .i_wdata (wr_word),
        .o_rdata (rd_word)
    );

    // build the column: new pixel on top of the stored rows, mask rows off frame
    t_rgb                          col_pix [KERNEL_SIZE];
    logic [NUM_CH-1:0][CSUM_W-1:0] col_sum;

    always_comb begin
        col_pix[0] = r_s1_pix;
        for (int k = 1; k < KERNEL_SIZE; k++) begin
            col_pix[k] = rd_word[(k - 1) * RGB_W +: RGB_W];
        end
        wr_word[0 +: RGB_W] = r_s1_pix;
        for (int i = 1; i < TAPS; i++) begin
            wr_word[i * RGB_W +: RGB_W] = rd_word[(i - 1) * RGB_W +: RGB_W];
        end
        col_sum = '0;
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            if ((r_s1_row >= ROW_W'(k)) && (r_s1_row < ROW_W'(r_s1_fh) + ROW_W'(k))) begin
                col_sum[0] = col_sum[0] + CSUM_W'(col_pix[k].red);
                col_sum[1] = col_sum[1] + CSUM_W'(col_pix[k].green);
                col_sum[2] = col_sum[2] + CSUM_W'(col_pix[k].blue);
            end
        end
    end

    // stage 2: chain of column cells
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_meta <= r_s1_meta;
        end
    end

    logic [NUM_CH-1:0][CSUM_W-1:0] cell_col_in  [KERNEL_SIZE];
    logic [NUM_CH-1:0][CSUM_W-1:0] cell_col_out [KERNEL_SIZE];
    logic [NUM_CH-1:0][ACC_W-1:0]  cell_acc_in  [KERNEL_SIZE];
    logic [NUM_CH-1:0][ACC_W-1:0]  cell_acc_out [KERNEL_SIZE];
    logic [KERNEL_SIZE-1:0]        cell_incl;
    logic [OW-1:0]                 oc_right;

    // a cell counts only if its column is inside the frame for this result
    always_comb begin
        oc_right = OW'(r_s2_meta.oc) + OW'(LAG);
        for (int j = 0; j < KERNEL_SIZE; j++) begin
            cell_incl[j] = (oc_right >= OW'(j))
                        && ((oc_right - OW'(j)) < OW'(r_s2_meta.fw));
        end
    end

    for (genvar j = 0; j < KERNEL_SIZE; j++) begin : g_cell
        if (j == 0) begin : g_head
            assign cell_col_in[j] = col_sum;
            assign cell_acc_in[j] = '0;
        end else begin : g_link
            assign cell_col_in[j] = cell_col_out[j-1];
            assign cell_acc_in[j] = cell_acc_out[j-1];
        end

        rbb_cell #(
            .SUM_W (CSUM_W),
            .ACC_W (ACC_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (adv && r_s1_v),
            .i_col   (cell_col_in[j]),
            .o_col   (cell_col_out[j]),
            .i_incl  (cell_incl[j]),
            .i_acc   (cell_acc_in[j]),
            .o_acc   (cell_acc_out[j])
        );
    end

    // stage 3: hold the window sum
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_meta <= r_s2_meta;
            r_s3_sum  <= cell_acc_out[KERNEL_SIZE-1];
        end
    end

    // divide by K*K through an exact reciprocal multiply
    logic [PROD_W-1:0] prod [NUM_CH];
    t_rgb              quot;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            prod[c] = PROD_W'(r_s3_sum[c]) * PROD_W'(MUL);
        end
        quot = '{blue:  prod[2][SHIFT +: PIX_W],
                 green: prod[1][SHIFT +: PIX_W],
                 red:   prod[0][SHIFT +: PIX_W]};
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_pix  <= quot;
            r_out_last <= r_s3_meta.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out_pix.red;
    assign o_out_green = r_out_pix.green;
    assign o_out_blue  = r_out_pix.blue;
    assign o_frame_end = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/rbb_line_buf.sv =====
// ---------------------------------------------------------------------------
// rbb_line_buf: line buffer memory
// One word per column holding the previous rows; registered read with
// bypass of a write to the same address in the same cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rbb_line_buf #(
    parameter int DEPTH  = 1024,
    parameter int WORD_W = 96
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WORD_W-1:0]        i_wdata,
    output logic      [WORD_W-1:0]        o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_q;
    logic [WORD_W-1:0] r_byp_data;
    logic              r_byp;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, hold while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q        <= r_mem[i_raddr];
            r_byp      <= i_we && (i_waddr == i_raddr);
            r_byp_data <= i_wdata;
        end
    end

    assign o_rdata = r_byp ? r_byp_data : r_q;

endmodule

`default_nettype wire

// ===== rtl/core/rbb_cell.sv =====
// ---------------------------------------------------------------------------
// rbb_cell: one column cell of the blur window
// Holds one column sum, hands it to the next cell on shift, and adds it
// into the running window sum when its column lies inside the frame.
// ---------------------------------------------------------------------------
`default_nettype none

module rbb_cell #(
    parameter int SUM_W = 11,
    parameter int ACC_W = 13
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_shift,
    input  wire logic [rbb_pkg::NUM_CH-1:0][SUM_W-1:0] i_col,
    output logic      [rbb_pkg::NUM_CH-1:0][SUM_W-1:0] o_col,
    input  wire logic                                 i_incl,
    input  wire logic [rbb_pkg::NUM_CH-1:0][ACC_W-1:0] i_acc,
    output logic      [rbb_pkg::NUM_CH-1:0][ACC_W-1:0] o_acc
);

    import rbb_pkg::*;

    logic [NUM_CH-1:0][SUM_W-1:0] r_col;

    // advance the column sum along the chain
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

    // add this column into the partial window sum
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            o_acc[c] = i_acc[c] + (i_incl ? ACC_W'(r_col[c]) : ACC_W'(0));
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rbb_checker.sv =====
// ---------------------------------------------------------------------------
// rbb_checker: port level checks for the RGB box blur
// Watches the handshakes of the top level; bound to it below.
// ---------------------------------------------------------------------------
`default_nettype none

module rbb_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      o_in_stall,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_stall,
    input wire logic [rbb_pkg::PIX_W-1:0] o_out_red,
    input wire logic [rbb_pkg::PIX_W-1:0] o_out_green,
    input wire logic [rbb_pkg::PIX_W-1:0] o_out_blue,
    input wire logic                      o_frame_end
);

    import rbb_pkg::*;

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // input stalls only when a held result is being stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with free output slot");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable({o_out_red, o_out_green, o_out_blue, o_frame_end})))
        else $error("stalled result beat changed");

    // an offered input beat is never stalled while the output register is empty
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_out_valid) |-> !o_in_stall)
        else $error("input stalled while output empty");

endmodule

bind rgb_box_blur_5x5_unit rbb_checker u_rbb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_red   (o_out_red),
    .o_out_green (o_out_green),
    .o_out_blue  (o_out_blue),
    .o_frame_end (o_frame_end)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: self-checking bench for rgb_box_blur_5x5_unit
// Streams whole frames of random, black or white pixels with drain beats
// through the blur, predicts every blurred pixel and checks each output beat field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    import rbb_pkg::*;

    localparam int LINE_W      = 1024;
    localparam int STORE_ROWS  = 6;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE      = 12;

    typedef struct {
        logic cmd;
        t_rgb px;
    } t_beat;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             frame_end;
    } t_blur;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_command = CMD_PIXEL;
    logic [PIX_W-1:0]      i_pixel_red = '0;
    logic [PIX_W-1:0]      i_pixel_green = '0;
    logic [PIX_W-1:0]      i_pixel_blue = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [PIX_W-1:0]      o_out_red;
    logic [PIX_W-1:0]      o_out_green;
    logic [PIX_W-1:0]      o_out_blue;
    logic                  o_frame_end;

    rgb_box_blur_5x5_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_pixel_red   (i_pixel_red),
        .i_pixel_green (i_pixel_green),
        .i_pixel_blue  (i_pixel_blue),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_frame_end   (o_frame_end)
    );

    always #2 i_clk = ~i_clk;

    // shadow state of the blur
    t_rgb  row_mem [STORE_ROWS*LINE_W];
    int    reg_width  = WIDTH_RESET;
    int    reg_height = HEIGHT_RESET;
    int    frame_w, frame_h;
    int    in_col, in_row, out_col, out_row;

    t_beat pending_beats[$];
    t_blur blurred_q[$];
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    err_count = 0;
    int    beats_in = 0;
    int    pixels_out = 0;
    int    frames_done = 0;
    int    idle_cycles = 0;

    function automatic int fit_dim(int v, int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // advance the shadow blur by one accepted beat
    task automatic blur_step(input logic cmd, input t_rgb px);
        int    pos;
        int    sr, sg, sb;
        t_blur res;
        t_rgb  p;
        if (in_row == 0 && in_col == 0) begin
            if (cmd == CMD_DRAIN) return;
            frame_w = fit_dim(reg_width, LINE_W);
            frame_h = fit_dim(reg_height, MAX_HEIGHT);
        end
        if (in_row < frame_h) begin
            if (cmd == CMD_DRAIN) return;
            row_mem[(in_row % STORE_ROWS)*LINE_W + in_col] = px;
        end
        pos = in_row * frame_w + in_col;
        in_col++;
        if (in_col >= frame_w) begin
            in_col = 0;
            in_row++;
        end
        if (pos < 2*frame_w + 2) return;
        sr = 0; sg = 0; sb = 0;
        for (int r = out_row - 2; r <= out_row + 2; r++) begin
            if (r < 0 || r >= frame_h) continue;
            for (int c = out_col - 2; c <= out_col + 2; c++) begin
                if (c < 0 || c >= frame_w) continue;
                p = row_mem[(r % STORE_ROWS)*LINE_W + c];
                sr += p.red; sg += p.green; sb += p.blue;
            end
        end
        res.red = PIX_W'(sr / 25);
        res.green = PIX_W'(sg / 25);
        res.blue = PIX_W'(sb / 25);
        res.frame_end = (out_row + 1 >= frame_h) && (out_col + 1 >= frame_w);
        blurred_q.push_back(res);
        if (res.frame_end) begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end else begin
            out_col++;
            if (out_col >= frame_w) begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    task automatic report(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        err_count++;
    endtask

    // driver: hold a stalled beat, otherwise offer the next one or idle
    always @(posedge i_clk) begin
        t_beat b;
        if (i_rst_n && (!i_in_valid || !o_in_stall)) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                b = pending_beats.pop_front();
                i_in_valid    <= 1'b1;
                i_command     <= b.cmd;
                i_pixel_red   <= b.px.red;
                i_pixel_green <= b.px.green;
                i_pixel_blue  <= b.px.blue;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // monitor: check output beats, predict from input beats, watch for hangs
    always @(posedge i_clk) begin
        t_blur got, want;
        t_rgb  px;
        bit    moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                pixels_out++;
                got = {o_out_red, o_out_green, o_out_blue, o_frame_end};
                if (blurred_q.size() == 0) begin
                    report($sformatf("unexpected output beat %h", got));
                end else begin
                    want = blurred_q.pop_front();
                    if (got.red !== want.red)
                        report($sformatf("red %h, want %h", got.red, want.red));
                    if (got.green !== want.green)
                        report($sformatf("green %h, want %h", got.green, want.green));
                    if (got.blue !== want.blue)
                        report($sformatf("blue %h, want %h", got.blue, want.blue));
                    if (got.frame_end !== want.frame_end)
                        report($sformatf("frame_end %b, want %b",
                                         got.frame_end, want.frame_end));
                    if (want.frame_end) frames_done++;
                end
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                beats_in++;
                px.red = i_pixel_red;
                px.green = i_pixel_green;
                px.blue = i_pixel_blue;
                blur_step(i_command, px);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("rgb_box_blur_5x5_unit test failed");
                $finish;
            end
        end
    end

    // wait until every beat is in and every result is out, then settle
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (pending_beats.size() != 0 || i_in_valid || blurred_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) reg_width = val & 'h7FF;
        else reg_height = val & 'h1FFF;
    endtask

    function automatic t_rgb rand_px();
        return t_rgb'(RGB_W'($urandom_range(24'hFFFFFF)));
    endfunction

    function automatic void push_beat(input logic cmd, input t_rgb px);
        t_beat b;
        b.cmd = cmd;
        b.px = px;
        pending_beats.push_back(b);
    endfunction

    // queue one frame; fill selects the pixel pattern (0 random, 1 black, 2 white)
    task automatic run_frame(input int w_reg, input int h_reg, input int fill,
                             input bit noisy);
        int   w, h;
        t_rgb px;
        if (w_reg != reg_width || h_reg != reg_height) begin
            wait_quiet();
            write_reg(CFG_IMAGE_WIDTH, w_reg);
            write_reg(CFG_IMAGE_HEIGHT, h_reg);
        end
        w = fit_dim(w_reg & 'h7FF, LINE_W);
        h = fit_dim(h_reg & 'h1FFF, MAX_HEIGHT);
        // drain beats before the first pixel are ignored
        if (noisy && $urandom_range(3) == 0) push_beat(CMD_DRAIN, rand_px());
        for (int k = 0; k < w*h; k++) begin
            if (noisy && $urandom_range(9) == 0) push_beat(CMD_DRAIN, rand_px());
            if (fill == 1) px = '0;
            else if (fill == 2) px = '1;
            else px = rand_px();
            push_beat(CMD_PIXEL, px);
        end
        // flush: pixels past the frame end act as drain beats
        for (int k = 0; k < 2*w + 2; k++)
            push_beat((noisy && $urandom_range(1)) ? CMD_PIXEL : CMD_DRAIN, rand_px());
    endtask

    initial begin
        int budget;
        int w, h;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        frame_w = fit_dim(reg_width, LINE_W);
        frame_h = fit_dim(reg_height, MAX_HEIGHT);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes of the frame size and of the pixel values
        send_idle_pct = 35;
        recv_idle_pct = 75;
        run_frame(1, 1, 2, 1'b0);
        run_frame(0, 0, 0, 1'b1);
        run_frame(3, 3, 2, 1'b0);
        run_frame(3, 3, 1, 1'b0);
        run_frame(5, 4, 0, 1'b1);

        // random frames, mostly small, under three idling patterns
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 75;
                recv_idle_pct = 35;
            end else if (ph == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            budget = 125;
            while (budget > 0) begin
                if ($urandom_range(7) == 0) begin
                    w = $urandom_range(40, 1);
                    h = $urandom_range(3, 1);
                end else begin
                    w = $urandom_range(7, 1);
                    h = $urandom_range(7, 1);
                end
                run_frame(w, h, 0, $urandom_range(3) != 0);
                budget -= w*h;
            end
        end

        // one more tiny frame after the random mix
        run_frame(2, 2, 0, 1'b1);

        wait_quiet();
        $display("covered %0d frames: %0d input beats, %0d blurred pixels checked",
                 frames_done, beats_in, pixels_out);
        $display("frame sizes from 1x1 to 40 wide and 7 tall, zero registers too, %0d mismatches",
                 err_count);
        if (err_count == 0) begin
            $display("rgb_box_blur_5x5_unit test passed");
        end else begin
            $display("rgb_box_blur_5x5_unit test failed");
        end
        $finish;
    end

endmodule
